/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that cons holds at the next edge after every edge at which ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/rne_pkg.sv */
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Types, constants and symbol tables shared by the encoder modules.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int unsigned VAL_W       = 12;
    localparam int unsigned NUM_ENTRIES = 13;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned STAR_W      = 2;

    localparam logic [31:0]       LIMIT_VALUE = 32'd3999;
    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_NONE     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_M        = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_D        = 8'h44;
    localparam logic [CHAR_W-1:0] CH_C        = 8'h43;
    localparam logic [CHAR_W-1:0] CH_L        = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_X        = 8'h58;
    localparam logic [CHAR_W-1:0] CH_V        = 8'h56;
    localparam logic [CHAR_W-1:0] CH_I        = 8'h49;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STAR
    } t_state;

    typedef struct packed {
        logic              emit;
        logic              sub;
        logic              last;
        logic [CHAR_W-1:0] symbol;
        logic [VAL_W-1:0]  next_value;
    } t_step;

    function automatic logic [VAL_W-1:0] f_weight(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] w;
        case (idx)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            4'd12:   w = 12'd1;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] f_first(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = CH_M;
            4'd1:    c = CH_C;
            4'd2:    c = CH_D;
            4'd3:    c = CH_C;
            4'd4:    c = CH_C;
            4'd5:    c = CH_X;
            4'd6:    c = CH_L;
            4'd7:    c = CH_X;
            4'd8:    c = CH_X;
            4'd9:    c = CH_I;
            4'd10:   c = CH_V;
            4'd11:   c = CH_I;
            4'd12:   c = CH_I;
            default: c = CH_I;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] f_second(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd1:    c = CH_M;
            4'd3:    c = CH_D;
            4'd5:    c = CH_C;
            4'd7:    c = CH_L;
            4'd9:    c = CH_X;
            4'd11:   c = CH_V;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

/* hdl/rne_step_unit.sv */
// ----------------------------------------------------------------------------
// Roman numeral step unit
// Shared compare and subtract against one table entry, with symbol selection.
// ----------------------------------------------------------------------------
module rne_step_unit (
    input  logic [rne_pkg::VAL_W-1:0] i_value,
    input  logic [rne_pkg::IDX_W-1:0] i_idx,
    input  logic                      i_second,
    output rne_pkg::t_step            o_step
);

    logic [rne_pkg::VAL_W-1:0]  weight;
    logic [rne_pkg::CHAR_W-1:0] second_char;
    logic                       is_pair;
    logic                       ge;
    logic [rne_pkg::VAL_W-1:0]  diff;

    assign weight      = rne_pkg::f_weight(i_idx);
    assign second_char = rne_pkg::f_second(i_idx);
    assign is_pair     = (second_char != rne_pkg::CH_NONE);
    assign ge          = (i_value >= weight);
    assign diff        = i_value - weight;

    always_comb begin
        o_step.emit       = ge;
        o_step.sub        = ge && (!is_pair || i_second);
        o_step.last       = o_step.sub && (diff == '0);
        o_step.symbol     = (is_pair && i_second) ? second_char
                                                  : rne_pkg::f_first(i_idx);
        o_step.next_value = diff;
    end

endmodule

/* hdl/roman_numeral_encoder.sv */
// ----------------------------------------------------------------------------
// Roman numeral encoder
// Converts one signed integer per transaction into a run of ASCII numeral
// characters, one output transaction per character, with a last flag.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Payload
//  input    i_valid / o_ready   i_value[31:0] signed
//  output   o_valid / i_ready   o_symbol[7:0], o_last, o_empty_res
//
//  A zero or negative value gives one empty result, valid the cycle after
//  acceptance.
//  Values up to 3999 go to the single compare and subtract unit, which per step
//  emits a character or skips a table entry; larger values give four '*'s.
//  Reset is synchronous and active low; it returns the sequencer to idle.
//  A stalled output holds the sequencer; no new input is taken until done.
// ----------------------------------------------------------------------------
module roman_numeral_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_symbol,
    output logic        o_last,
    output logic        o_empty_res
);

    rne_pkg::t_state r_state, n_state;
    logic [rne_pkg::VAL_W-1:0]  r_value, n_value;
    logic [rne_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                       r_second, n_second;
    logic [rne_pkg::STAR_W-1:0] r_star, n_star;
    logic                       r_out_valid, n_out_valid;
    logic [rne_pkg::CHAR_W-1:0] r_symbol, n_symbol;
    logic                       r_last, n_last;
    logic                       r_empty, n_empty;

    rne_pkg::t_step step;
    logic can_emit;
    logic accept;
    logic is_empty;
    logic is_big;

    rne_step_unit u_step (
        .i_value  (r_value),
        .i_idx    (r_idx),
        .i_second (r_second),
        .o_step   (step)
    );

    assign can_emit = !r_out_valid || i_ready;
    assign o_ready  = (r_state == rne_pkg::ST_IDLE) && can_emit;
    assign accept   = i_valid && o_ready;
    assign is_empty = i_value[31] || (i_value == 32'd0);
    assign is_big   = (i_value > rne_pkg::LIMIT_VALUE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            rne_pkg::ST_IDLE: begin
                if (accept && !is_empty) begin
                    n_state = is_big ? rne_pkg::ST_STAR : rne_pkg::ST_CONV;
                end
            end
            rne_pkg::ST_CONV: begin
                if (can_emit && step.last) begin
                    n_state = rne_pkg::ST_IDLE;
                end
            end
            rne_pkg::ST_STAR: begin
                if (can_emit && (r_star == '1)) begin
                    n_state = rne_pkg::ST_IDLE;
                end
            end
            default: n_state = rne_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_value     = r_value;
        n_idx       = r_idx;
        n_second    = r_second;
        n_star      = r_star;
        n_out_valid = r_out_valid && !i_ready;
        n_symbol    = r_symbol;
        n_last      = r_last;
        n_empty     = r_empty;
        case (r_state)
            rne_pkg::ST_IDLE: begin
                if (accept) begin
                    n_value  = i_value[rne_pkg::VAL_W-1:0];
                    n_idx    = '0;
                    n_second = 1'b0;
                    n_star   = '0;
                    if (is_empty) begin
                        n_out_valid = 1'b1;
                        n_symbol    = rne_pkg::CH_NONE;
                        n_last      = 1'b1;
                        n_empty     = 1'b1;
                    end
                end
            end
            rne_pkg::ST_CONV: begin
                if (can_emit) begin
                    if (step.emit) begin
                        n_out_valid = 1'b1;
                        n_symbol    = step.symbol;
                        n_last      = step.last;
                        n_empty     = 1'b0;
                        if (step.sub) begin
                            n_value  = step.next_value;
                            n_second = 1'b0;
                        end else begin
                            n_second = 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            rne_pkg::ST_STAR: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_symbol    = rne_pkg::CH_STAR;
                    n_last      = (r_star == '1);
                    n_empty     = 1'b0;
                    n_star      = r_star + 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rne_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_second <= n_second;
        r_star   <= n_star;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_empty  <= n_empty;
    end

    assign o_valid     = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

endmodule

/* hdl/rne_checker.sv */
// ----------------------------------------------------------------------------
// Roman numeral encoder checker
// Port-level assertions on the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rne_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_value,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_symbol,
    input logic        o_last,
    input logic        o_empty_res
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_symbol))
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid && $stable(i_value))
    `ASSERT_CLK(a_empty_last, i_clk, i_rst_n, o_valid && o_empty_res |-> o_last)
    `ASSERT_CLK(a_empty_sym, i_clk, i_rst_n, o_valid && o_empty_res |-> o_symbol == 8'h00)
    `ASSERT_CLK(a_sym_set, i_clk, i_rst_n, o_valid && !o_empty_res |-> o_symbol != 8'h00)

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Roman numeral encoder testbench
// Drives signed integers into the encoder in bursts while the output side
// stalls on a rotating pattern. A scoreboard class spells out each accepted
// value as Roman numeral characters and checks every output transaction,
// field by field, against the oldest character still expected.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_ITEMS = 156;

    typedef struct {
        logic [31:0]                value;
        logic [rne_pkg::CHAR_W-1:0] symbol;
        logic                       last;
        logic                       empty_res;
    } t_numeral_char;

    class roman_scoreboard;
        t_numeral_char expected_q[$];
        int unsigned   errors;

        function void add_char(logic [31:0] value, logic [rne_pkg::CHAR_W-1:0] symbol,
                               logic empty_res);
            t_numeral_char c;
            c.value     = value;
            c.symbol    = symbol;
            c.last      = 1'b0;
            c.empty_res = empty_res;
            expected_q.push_back(c);
        endfunction

        function void note_value(logic [31:0] value);
            logic [rne_pkg::CHAR_W-1:0] one_ch[3];
            logic [rne_pkg::CHAR_W-1:0] five_ch[3];
            logic [rne_pkg::CHAR_W-1:0] ten_ch[3];
            int unsigned                weight[3];
            int unsigned                rest;
            int unsigned                digit;
            one_ch  = '{rne_pkg::CH_C, rne_pkg::CH_X, rne_pkg::CH_I};
            five_ch = '{rne_pkg::CH_D, rne_pkg::CH_L, rne_pkg::CH_V};
            ten_ch  = '{rne_pkg::CH_M, rne_pkg::CH_C, rne_pkg::CH_X};
            weight  = '{100, 10, 1};
            if (value[31] || value == 32'd0) begin
                add_char(value, rne_pkg::CH_NONE, 1'b1);
            end else if (value > rne_pkg::LIMIT_VALUE) begin
                repeat (4) add_char(value, rne_pkg::CH_STAR, 1'b0);
            end else begin
                rest = value;
                while (rest >= 1000) begin
                    add_char(value, rne_pkg::CH_M, 1'b0);
                    rest -= 1000;
                end
                for (int p = 0; p < 3; p++) begin
                    digit = rest / weight[p];
                    rest  = rest % weight[p];
                    if (digit == 9) begin
                        add_char(value, one_ch[p], 1'b0);
                        add_char(value, ten_ch[p], 1'b0);
                    end else if (digit == 4) begin
                        add_char(value, one_ch[p], 1'b0);
                        add_char(value, five_ch[p], 1'b0);
                    end else begin
                        if (digit >= 5) begin
                            add_char(value, five_ch[p], 1'b0);
                            digit -= 5;
                        end
                        repeat (digit) add_char(value, one_ch[p], 1'b0);
                    end
                end
            end
            expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_char(logic [rne_pkg::CHAR_W-1:0] symbol, logic last,
                                 logic empty_res);
            t_numeral_char c;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction symbol %h last %b empty %b",
                         $time, symbol, last, empty_res);
                errors++;
                return;
            end
            c = expected_q.pop_front();
            if (symbol !== c.symbol) begin
                $display("%0t: value %0d symbol expected %h actual %h",
                         $time, $signed(c.value), c.symbol, symbol);
                errors++;
            end
            if (last !== c.last) begin
                $display("%0t: value %0d last expected %b actual %b",
                         $time, $signed(c.value), c.last, last);
                errors++;
            end
            if (empty_res !== c.empty_res) begin
                $display("%0t: value %0d empty_res expected %b actual %b",
                         $time, $signed(c.value), c.empty_res, empty_res);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_symbol;
    logic        o_last;
    logic        o_empty_res;

    roman_scoreboard sb;
    int unsigned     cycle_count = 0;
    logic [11:0]     stall_pattern = 12'hFFF;
    int unsigned     pattern_age = 0;
    logic [31:0]     stim_q[$];

    roman_numeral_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("roman_numeral_encoder verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_value(i_value);
            if (o_valid && i_ready) sb.check_char(o_symbol, o_last, o_empty_res);
        end
    end

    always @(negedge i_clk) begin
        if (pattern_age == 47) begin
            pattern_age <= 0;
            if ($urandom_range(2) == 0) stall_pattern <= 12'hFFF;
            else stall_pattern <= 12'($urandom) | 12'h001;
            i_ready <= 1'b1;
        end else begin
            pattern_age   <= pattern_age + 1;
            stall_pattern <= {stall_pattern[10:0], stall_pattern[11]};
            i_ready       <= stall_pattern[11];
        end
    end

    task automatic send_value(input logic [31:0] value);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_value <= $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(1, 3999);
            5:             return $urandom_range(3000, 3999);
            6:             return $urandom_range(4000, 32'h7FFF_FFFF);
            7:             return 32'h8000_0000 | $urandom;
            8:             return $urandom_range(0, 20);
            default:       return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned burst;
        int unsigned idx;
        sb      = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = 32'd0;
        stim_q = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1,
                   32'd3999, 32'd4000, 32'd3888, 32'd4, 32'd9, 32'd40, 32'd90,
                   32'd400, 32'd900, 32'd5, 32'd50, 32'd500, 32'd1000, 32'd2,
                   32'd14, 32'd49, 32'd944, 32'd1994, 32'd3000};
        repeat (RANDOM_ITEMS) stim_q.push_back(random_value());
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idx = 0;
        while (idx < stim_q.size()) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && idx < stim_q.size()) begin
                send_value(stim_q[idx]);
                idx++;
                burst--;
            end
            if ($urandom_range(3) != 0) idle_sender($urandom_range(1, 6));
        end
        idle_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("roman_numeral_encoder verification clean");
        end else begin
            $display("roman_numeral_encoder verification failed");
        end
        $finish;
    end
endmodule
